// File: rtl/core/frame_crc32_trailer_check_unit_assert.svh
// Assertion macros for the frame CRC trailer check block.
`ifndef FRAME_CRC32_TRAILER_CHECK_UNIT_ASSERT_SVH
`define FRAME_CRC32_TRAILER_CHECK_UNIT_ASSERT_SVH

// Implication sampled on clk, off while arst_n is low.
`define FCTC_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication sampled on clk, off while arst_n is low.
`define FCTC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/core/fctc_pkg.sv
package fctc_pkg;

	localparam logic [31:0] CRC_POLY     = 32'h04C11DB7;
	localparam logic [2:0]  WINDOW_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        crc_ok;
		logic        frame_too_short;
		logic [31:0] computed_crc;
		logic [31:0] received_crc;
	} result_t;

	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctrl_t;

	function automatic logic [31:0] crc32_add_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// File: rtl/core/frame_crc32_trailer_check_unit.sv
// Frame CRC-32 trailer checker.
// item channel: one frame byte per transaction (item_valid / item_stall),
//   last_byte marks the fourth trailer byte. Frame bytes before the trailer
//   feed a CRC-32, poly 0x04C11DB7, init 0, no final xor, MSB first.
// result channel: one transaction per frame (result_valid / result_stall),
//   carrying crc_ok, frame_too_short, computed_crc and received_crc.
// cfg_we / cfg_data write trailer_big_endian (reset 1); write only when idle.
// Path: a last byte goes from the input register into the result register, which drives result_valid.
// Throughput: one byte per cycle while item_stall is low; the CRC byte update is
//   a single xor tree between the CRC/window state and the state/result registers.
// Stall: bytes that are not last keep flowing while a result waits; a last
//   byte holds in the input register until the result register frees, and
//   item_stall is high only while it holds.
// Reset: all control state and the CRC/window clear; frames under four
//   bytes report frame_too_short with zeroed CRC fields.
module frame_crc32_trailer_check_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fctc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output fctc_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_data
);
	import fctc_pkg::*;

	item_t       item_s1;
	stage_ctrl_t ctrl;
	result_t     res;
	result_t     result_q;
	logic        result_valid_q;
	logic        big_endian_q;
	logic        out_blocked;
	logic        load;

	assign out_blocked = result_valid_q && result_stall;
	assign load        = ctrl.valid && ctrl.advance && item_s1.last_byte;

	fctc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.out_blocked(out_blocked),
		.item_s1    (item_s1),
		.ctrl       (ctrl)
	);

	fctc_frame_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.item_s1   (item_s1),
		.big_endian(big_endian_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_we) begin
			big_endian_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule

// File: rtl/core/fctc_in_stage.sv
module fctc_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  fctc_pkg::item_t      item,
	input  logic                 out_blocked,
	output fctc_pkg::item_t      item_s1,
	output fctc_pkg::stage_ctrl_t ctrl
);
	import fctc_pkg::*;

	logic valid_s1;
	logic advance;
	logic accept;

	// A non-last byte never needs the result register, so it moves on regardless.
	assign advance    = valid_s1 && !(item_s1.last_byte && out_blocked);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	assign ctrl.valid   = valid_s1;
	assign ctrl.advance = advance;
endmodule

// File: rtl/core/fctc_frame_track.sv
module fctc_frame_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fctc_pkg::stage_ctrl_t ctrl,
	input  fctc_pkg::item_t       item_s1,
	input  logic                  big_endian,
	output fctc_pkg::result_t     res
);
	import fctc_pkg::*;

	logic [31:0] crc_acc_q;
	logic [31:0] window_q;
	logic [2:0]  fill_q;

	logic        full;
	logic [2:0]  fill_next;
	logic [31:0] crc_next;
	logic [31:0] window_next;
	logic [31:0] received;
	logic        too_short;

	always_comb begin
		full        = (fill_q == WINDOW_BYTES);
		fill_next   = full ? fill_q : fill_q + 3'd1;
		crc_next    = full ? crc32_add_byte(crc_acc_q, window_q[31:24]) : crc_acc_q;
		window_next = {window_q[23:0], item_s1.data_byte};
		too_short   = (fill_next != WINDOW_BYTES);
		received    = big_endian ? window_next : swap_bytes(window_next);
		if (too_short) begin
			res.crc_ok          = 1'b0;
			res.frame_too_short = 1'b1;
			res.computed_crc    = 32'h0;
			res.received_crc    = 32'h0;
		end else begin
			res.crc_ok          = (received == crc_next);
			res.frame_too_short = 1'b0;
			res.computed_crc    = crc_next;
			res.received_crc    = received;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc_q <= 32'h0;
			window_q  <= 32'h0;
			fill_q    <= 3'd0;
		end else if (ctrl.valid && ctrl.advance) begin
			if (item_s1.last_byte) begin
				crc_acc_q <= 32'h0;
				window_q  <= 32'h0;
				fill_q    <= 3'd0;
			end else begin
				crc_acc_q <= crc_next;
				window_q  <= window_next;
				fill_q    <= fill_next;
			end
		end
	end
endmodule

// File: rtl/core/fctc_checker.sv
`include "frame_crc32_trailer_check_unit_assert.svh"

module fctc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input fctc_pkg::result_t result
);
	import fctc_pkg::*;

	logic out_held;
	logic short_zero;
	logic ok_consistent;

	assign out_held      = result_valid && result_stall;
	assign short_zero    = !result.crc_ok && (result.computed_crc == 32'h0)
		&& (result.received_crc == 32'h0);
	assign ok_consistent = result.crc_ok == (result.computed_crc == result.received_crc);

	`FCTC_ASSERT_NEXT(a_result_held, out_held, result_valid, "result dropped while stalled")
	`FCTC_ASSERT_IMPL(a_short_fields, result_valid && result.frame_too_short, short_zero, "bad short")
	`FCTC_ASSERT_IMPL(a_ok_match, result_valid && !result.frame_too_short, ok_consistent, "crc_ok bad")
	`FCTC_ASSERT_IMPL(a_stall_cause, item_stall, out_held, "input stalled without output backpressure")
endmodule

bind frame_crc32_trailer_check_unit fctc_checker u_fctc_checker (.*);
